// ===== design/erps_pkg.sv =====
// Package for the entropy recycling path selector.
// Holds widths, ring geometry, opcode and register codes and the item structs.
// No dependencies; used by every module in the design folder.
`default_nettype none

package erps_pkg;

  // Ring geometry.
  localparam int RingDepth = 16;
  localparam int IdxW      = $clog2(RingDepth);
  localparam int CntW      = $clog2(RingDepth + 1);

  localparam int EntW  = 16;
  localparam int TimeW = 48;
  localparam int ToutW = 32;
  localparam int CfgW  = 32;
  localparam int CfgIdxW = 2;

  localparam int InDataW  = 136;
  localparam int OutDataW = 120;

  localparam logic [EntW-1:0]  ResetTimeout = EntW'(0);
  localparam logic [ToutW-1:0] TimeoutInit  = ToutW'(1000);

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_FAIL = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXPLORE_START = 2'd0,
    REG_BDP_PACKETS   = 2'd1,
    REG_FREEZE_TOUT   = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [TimeW-1:0] now_ns;
    logic [EntW-1:0]  fresh_entropy;
    logic [EntW-1:0]  ack_entropy;
    logic [TimeW-1:0] ack_send_time;
    logic             ack_congestion;
  } in_item_t;

  typedef struct packed {
    logic [EntW-1:0]  entropy;
    logic [TimeW-1:0] send_stamp;
    logic [TimeW-1:0] round_trip;
    logic             explored;
    logic             freezing;
  } out_item_t;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== design/entropy_recycling_path_selector_top.sv =====
// Top level of the entropy recycling path selector: stream ports and packing.
// Depends on erps_pkg, erps_in_stage and erps_core.
//
//  channel | direction | handshake               | payload
//  s_axis  | in        | s_axis_tvalid/tready    | tuser opcode, tdata event fields
//  m_axis  | out       | m_axis_tvalid/tready    | tdata result fields
//  cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// Each item passes an input register and a result register. One item per cycle
// is sustained while m_axis_tready holds, set by the single-step state update.
// Reset clears the ring to zero with all entries invalid and loads the timeout
// with 1000 ns. A stalled output holds its result while the input register
// still takes one more item.
`default_nettype none

module entropy_recycling_path_selector_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // [128] ack_congestion, [127:80] ack_send_time, [79:64] ack_entropy,
  // [63:48] fresh_entropy, [47:0] now_ns, rest zero
  input  wire [erps_pkg::InDataW-1:0]       s_axis_tdata,
  // [1:0] opcode
  input  wire [1:0]                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // [113] freezing, [112] explored, [111:64] round_trip, [63:16] send_stamp,
  // [15:0] entropy, rest zero
  output logic [erps_pkg::OutDataW-1:0]     m_axis_tdata,
  input  wire                               cfg_we_i,
  input  wire [erps_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [erps_pkg::CfgW-1:0]          cfg_wdata_i
);

  erps_pkg::in_item_t  in_item, core_item;
  erps_pkg::out_item_t out_item;
  erps_pkg::cfg_wr_t   cfg;
  logic                core_valid;
  logic                core_take;

  assign in_item.opcode         = s_axis_tuser;
  assign in_item.now_ns         = s_axis_tdata[47:0];
  assign in_item.fresh_entropy  = s_axis_tdata[63:48];
  assign in_item.ack_entropy    = s_axis_tdata[79:64];
  assign in_item.ack_send_time  = s_axis_tdata[127:80];
  assign in_item.ack_congestion = s_axis_tdata[128];

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  erps_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (core_valid),
    .take_i  (core_take),
    .item_o  (core_item)
  );

  erps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (core_valid),
    .item_i      (core_item),
    .take_o      (core_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {6'b0, out_item.freezing, out_item.explored,
                         out_item.round_trip, out_item.send_stamp, out_item.entropy};

endmodule

`default_nettype wire

// ===== design/erps_in_stage.sv =====
// Input register stage of the entropy recycling path selector.
// Depends on erps_pkg for the input item struct.
`default_nettype none

module erps_in_stage (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  ready_o,
  input  erps_pkg::in_item_t    item_i,
  output logic                  valid_o,
  input  wire                   take_i,
  output erps_pkg::in_item_t    item_o
);

  logic               valid_q;
  erps_pkg::in_item_t item_q;

  // The stage refills in the same cycle in which the core takes its item.
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/erps_core.sv =====
// Decision core: entropy ring, freeze and explore state, and the result register.
// Depends on erps_pkg for geometry, codes and item structs.
`default_nettype none

module erps_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  erps_pkg::cfg_wr_t     cfg_i,
  input  wire                   valid_i,
  input  erps_pkg::in_item_t    item_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output erps_pkg::out_item_t   out_item_o
);

  localparam int IdxW = erps_pkg::IdxW;
  localparam int CntW = erps_pkg::CntW;

  logic [erps_pkg::EntW-1:0]  ring_q [erps_pkg::RingDepth];
  logic [erps_pkg::RingDepth-1:0] valid_q, valid_d;
  logic [IdxW-1:0]            head_q, head_d;
  logic [CntW-1:0]            vcount_q, vcount_d;
  logic                       never_filled_q, never_filled_d;
  logic                       freeze_q, freeze_d;
  logic [erps_pkg::TimeW-1:0] exit_q, exit_d;
  logic [erps_pkg::EntW-1:0]  explore_q, explore_d;
  logic [erps_pkg::EntW-1:0]  bdp_q;
  logic [erps_pkg::ToutW-1:0] tout_q;

  logic                       out_valid_q;
  erps_pkg::out_item_t        out_q, out_d;

  logic [IdxW-1:0]            head_inc;
  logic [IdxW:0]              old_sum;
  logic [IdxW-1:0]            oldest;
  logic [IdxW-1:0]            rd_pos;
  logic [erps_pkg::EntW-1:0]  rd_ent;
  logic                       explore_now;
  logic                       ring_we;
  logic [erps_pkg::TimeW-1:0] exit_diff;

  assign take_o      = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign head_inc = (head_q == IdxW'(erps_pkg::RingDepth - 1)) ? '0 : head_q + 1'b1;

  // Oldest valid entry sits valid-count places behind the head, modulo the depth.
  assign old_sum = {1'b0, head_q} + (IdxW + 1)'(erps_pkg::RingDepth)
                   - (IdxW + 1)'(vcount_q);
  assign oldest  = (old_sum >= (IdxW + 1)'(erps_pkg::RingDepth))
                   ? IdxW'(old_sum - (IdxW + 1)'(erps_pkg::RingDepth))
                   : IdxW'(old_sum);
  assign rd_pos  = (vcount_q != '0) ? oldest : head_q;
  assign rd_ent  = ring_q[rd_pos];

  assign explore_now = never_filled_q || ((vcount_q == '0) && !freeze_q)
                       || (explore_q != '0);
  assign exit_diff   = item_i.now_ns - exit_q;

  always_comb begin
    valid_d        = valid_q;
    head_d         = head_q;
    vcount_d       = vcount_q;
    never_filled_d = never_filled_q;
    freeze_d       = freeze_q;
    exit_d         = exit_q;
    explore_d      = explore_q;
    ring_we        = 1'b0;
    out_d          = '0;

    if (take_o) begin
      case (item_i.opcode)
        erps_pkg::OP_SEND: begin
          out_d.send_stamp = item_i.now_ns;
          if (explore_now) begin
            out_d.entropy  = item_i.fresh_entropy;
            out_d.explored = 1'b1;
            if (explore_q != '0) begin
              explore_d = explore_q - 1'b1;
            end
          end else begin
            out_d.entropy = rd_ent;
            if (vcount_q != '0) begin
              valid_d[rd_pos] = 1'b0;
              vcount_d        = vcount_q - 1'b1;
            end else begin
              // Freezing with nothing valid: walk stale entries in ring order.
              head_d = head_inc;
            end
          end
        end
        erps_pkg::OP_ACK: begin
          out_d.round_trip = item_i.now_ns - item_i.ack_send_time;
          if (!item_i.ack_congestion) begin
            ring_we = 1'b1;
            if (!valid_q[head_q]) begin
              vcount_d = vcount_q + 1'b1;
            end
            valid_d[head_q] = 1'b1;
            head_d          = head_inc;
            never_filled_d  = 1'b0;
            if (freeze_q && (exit_diff != '0) && !exit_diff[erps_pkg::TimeW-1]) begin
              freeze_d  = 1'b0;
              explore_d = bdp_q;
            end
          end
        end
        erps_pkg::OP_FAIL: begin
          if (!freeze_q && (explore_q == '0)) begin
            freeze_d = 1'b1;
            exit_d   = item_i.now_ns + erps_pkg::TimeW'(tout_q);
          end
        end
        default: begin
        end
      endcase
      out_d.freezing = freeze_d;
    end

    // The user must write registers only while the block is idle; the block itself does not enforce it.
    if (cfg_i.we && (cfg_i.idx == erps_pkg::REG_EXPLORE_START)) begin
      explore_d = cfg_i.data[erps_pkg::EntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      head_q         <= '0;
      vcount_q       <= '0;
      never_filled_q <= 1'b1;
      freeze_q       <= 1'b0;
      exit_q         <= '0;
      explore_q      <= '0;
      bdp_q          <= '0;
      tout_q         <= erps_pkg::TimeoutInit;
      out_valid_q    <= 1'b0;
    end else begin
      valid_q        <= valid_d;
      head_q         <= head_d;
      vcount_q       <= vcount_d;
      never_filled_q <= never_filled_d;
      freeze_q       <= freeze_d;
      exit_q         <= exit_d;
      explore_q      <= explore_d;
      if (cfg_i.we && (cfg_i.idx == erps_pkg::REG_BDP_PACKETS)) begin
        bdp_q <= cfg_i.data[erps_pkg::EntW-1:0];
      end
      if (cfg_i.we && (cfg_i.idx == erps_pkg::REG_FREEZE_TOUT)) begin
        tout_q <= cfg_i.data[erps_pkg::ToutW-1:0];
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stale entries can be reused while freezing, so the ring resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < erps_pkg::RingDepth; i++) begin
        ring_q[i] <= erps_pkg::ResetTimeout;
      end
    end else if (ring_we) begin
      ring_q[head_q] <= item_i.ack_entropy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire
